### rtl/core/sida_pkg.sv
// Shared types and constants for the signed integer to decimal ASCII converter.
package sida_pkg;

	localparam int DEFAULT_VALUE_WIDTH = 32;
	localparam int CHAR_WIDTH = 7;

	localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO  = 7'd48;
	localparam logic [CHAR_WIDTH-1:0] ASCII_MINUS = 7'd45;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;        // capture a new value and clear the digit register
		logic conv_shift;  // one shift-and-correct step of the binary to BCD conversion
		logic digit_shift; // drop the top digit and move the next one up
		logic emit_sign;   // present a minus sign word
		logic emit_digit;  // present the top digit as a word
		logic last;        // the word presented now ends the text
	} sida_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic neg;      // the captured value is negative
		logic top_zero; // the top BCD digit is zero
	} sida_status_t;

endpackage

### rtl/core/sida_datapath.sv
// Datapath: magnitude register, BCD digit register and output word register.
module sida_datapath import sida_pkg::*; #(
	parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic signed [VALUE_WIDTH-1:0] value,
	input  sida_cmd_t                     cmd,
	output sida_status_t                  status,
	output logic [CHAR_WIDTH-1:0]         char_code,
	output logic                          last_char,
	output logic                          char_valid
);

	// Decimal digits needed for any VALUE_WIDTH-bit unsigned magnitude.
	localparam int DIGITS = (VALUE_WIDTH * 1233) / 4096 + 1;
	localparam int BCD_W  = DIGITS * 4;

	logic [VALUE_WIDTH-1:0] mag_q;
	logic [BCD_W-1:0]       bcd_q;
	logic [BCD_W-1:0]       bcd_adj;
	logic                   neg_q;
	logic [3:0]             top_digit;
	logic [CHAR_WIDTH-1:0]  char_code_q;
	logic                   last_char_q;
	logic                   char_valid_q;

	// Add three to every digit of five or more before the next shift.
	always_comb begin
		for (int i = 0; i < DIGITS; i++) begin
			if (bcd_q[i*4 +: 4] >= 4'd5) begin
				bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
			end else begin
				bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4];
			end
		end
	end

	assign top_digit = bcd_q[BCD_W-1 -: 4];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			neg_q <= value[VALUE_WIDTH-1];
			// Negating the most negative value leaves 2^(W-1), which is its magnitude.
			mag_q <= value[VALUE_WIDTH-1] ? (~value + 1'b1) : value;
			bcd_q <= '0;
		end else if (cmd.conv_shift) begin
			mag_q <= {mag_q[VALUE_WIDTH-2:0], 1'b0};
			bcd_q <= {bcd_adj[BCD_W-2:0], mag_q[VALUE_WIDTH-1]};
		end else if (cmd.digit_shift) begin
			bcd_q <= {bcd_q[BCD_W-5:0], 4'b0000};
		end
		if (cmd.emit_sign) begin
			char_code_q <= ASCII_MINUS;
		end else begin
			char_code_q <= ASCII_ZERO + {3'b000, top_digit};
		end
		last_char_q <= cmd.last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_valid_q <= 1'b0;
		end else begin
			char_valid_q <= cmd.emit_sign | cmd.emit_digit;
		end
	end

	assign status.neg      = neg_q;
	assign status.top_zero = (top_digit == 4'd0);
	assign char_code       = char_code_q;
	assign last_char       = last_char_q;
	assign char_valid      = char_valid_q;

endmodule

### rtl/core/sida_ctrl.sv
// Controller: sequences conversion steps, sign output and digit output.
module sida_ctrl import sida_pkg::*; #(
	parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  sida_status_t status,
	output sida_cmd_t    cmd,
	output logic         busy
);

	localparam int DIGITS = (VALUE_WIDTH * 1233) / 4096 + 1;
	localparam int CNT_W  = $clog2(VALUE_WIDTH);
	localparam int REM_W  = $clog2(DIGITS + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SIGN,
		ST_SKIP,
		ST_EMIT
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [REM_W-1:0] rem_q;
	logic             rem_one;

	assign rem_one = (rem_q == REM_W'(1));
	assign busy    = (state_q != ST_IDLE);

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.load = start;
			end
			ST_CONV: begin
				cmd.conv_shift = 1'b1;
			end
			ST_SIGN: begin
				cmd.emit_sign = 1'b1;
			end
			ST_SKIP: begin
				cmd.digit_shift = 1'b1;
				if (!(status.top_zero && !rem_one)) begin
					cmd.emit_digit = 1'b1;
					cmd.last       = rem_one;
				end
			end
			ST_EMIT: begin
				cmd.digit_shift = 1'b1;
				cmd.emit_digit  = 1'b1;
				cmd.last        = rem_one;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			rem_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_CONV;
						cnt_q   <= '0;
					end
				end
				ST_CONV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(VALUE_WIDTH - 1)) begin
						rem_q   <= REM_W'(DIGITS);
						state_q <= status.neg ? ST_SIGN : ST_SKIP;
					end
				end
				ST_SIGN: begin
					state_q <= ST_SKIP;
				end
				ST_SKIP, ST_EMIT: begin
					rem_q <= rem_q - 1'b1;
					if (cmd.emit_digit) begin
						state_q <= rem_one ? ST_IDLE : ST_EMIT;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

### rtl/core/signed_int_to_decimal_ascii.sv
// Top level of the signed integer to decimal ASCII converter.
// Usage: drive value and raise start; the value is taken at a rising edge where start is
// high and busy is low. busy then stays high until the last word of the text has been
// issued. The text comes out as one word per character on char_code, each present for
// exactly one cycle with char_valid high; last_char marks the final word. A negative
// value gives a leading minus sign, there are no leading zeros, and zero gives one '0'.
// The most negative value prints with magnitude 2^(VALUE_WIDTH-1).
// Operation: after acceptance the block runs VALUE_WIDTH shift-add-3 steps of a
// bit-serial binary to BCD conversion (one per cycle), a sign step when negative,
// then walks the DIGITS BCD digits one per cycle, skipping leading zeros and
// emitting the rest. The block takes no new value while busy is high; a new value
// may be accepted in the cycle the last word is shown.
// Reset clears the controller to idle and drops char_valid; no word is issued after it.
// The receiver cannot stall: every word must be taken in the cycle it is shown.
module signed_int_to_decimal_ascii import sida_pkg::*; #(
	parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [VALUE_WIDTH-1:0] value,
	output logic                          char_valid,
	output logic [CHAR_WIDTH-1:0]         char_code,
	output logic                          last_char
);

	// Commands and status passed between controller and datapath.
	sida_cmd_t    cmd;
	sida_status_t status;

	// The controller sequences conversion and output of each word.
	sida_ctrl #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	// The datapath holds the magnitude, the BCD digits and the registered output word.
	sida_datapath #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.value      (value),
		.cmd        (cmd),
		.status     (status),
		.char_code  (char_code),
		.last_char  (last_char),
		.char_valid (char_valid)
	);

endmodule
